// ===== hw/rtl/lph_pkg.sv =====
// Shared types, codes and sizes for the linear-probe hash lookup core.
// No dependencies; imported by lph_mod_unit and the top level.
package lph_pkg;

  localparam int MAX_BUCKETS = 1024;
  localparam int MAX_OBJECTS = 4096;
  localparam int SLOT_W      = $clog2(MAX_BUCKETS);
  localparam int BCNT_W      = 11;
  localparam int OLIM_W      = 13;
  localparam int KEY_W       = 32;
  localparam int OIDX_W      = 32;
  localparam int FIDX_W      = 12;
  localparam int CFG_W       = 13;
  localparam int ENTRY_W     = KEY_W + OIDX_W;

  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_BADCFG   = 2'd2;
  localparam logic [1:0] ST_WRITTEN  = 2'd3;

  localparam logic [1:0] CFG_BUCKET_COUNT = 2'd0;
  localparam logic [1:0] CFG_OBJECT_LIMIT = 2'd1;
  localparam logic [1:0] CFG_RANGE_MODE   = 2'd2;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_RD,
    S_CMP
  } lph_state_t;

  typedef struct packed {
    logic              go;
    logic [KEY_W-1:0]  dividend;
    logic [BCNT_W-1:0] divisor;
  } lph_mod_req_t;

  typedef struct packed {
    logic              done;
    logic [BCNT_W-1:0] rem;
  } lph_mod_rsp_t;

endpackage

// ===== hw/rtl/linear_probe_hash_lookup_core.sv =====
// Linear-probe hash lookup: bucket table in an internal memory, lookups probe with wrap.
// Depends on lph_pkg and lph_mod_unit.
// A write or a bad-configuration lookup gives its result in the cycle after start; busy stays low.
// A lookup first forms the home slot in the bit-serial remainder unit, then passes through
// a read state and a compare state for each probed slot on the table read port.
// Reset: control registers clear, then a clearing pass zeroes all 1024 slots; busy holds high.
module linear_probe_hash_lookup_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_req_type,
  input  logic [9:0]                 in_slot,
  input  logic [31:0]                in_key,
  input  logic [31:0]                in_object_index,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [9:0]                 out_found_slot,
  output logic [11:0]                out_found_index,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [lph_pkg::CFG_W-1:0]  cfg_wdata
);
  import lph_pkg::*;

  logic [ENTRY_W-1:0] mem [MAX_BUCKETS];
  logic [ENTRY_W-1:0] rd_data_r;

  lph_state_t        state_r, state_nxt;
  logic [SLOT_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [SLOT_W-1:0] cur_r, cur_nxt;
  logic [SLOT_W-1:0] home_r, home_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;

  logic [BCNT_W-1:0] bucket_count_r;
  logic [OLIM_W-1:0] object_limit_r;
  logic              range_mode_r;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [9:0]        out_slot_r, out_slot_nxt;
  logic [11:0]       out_index_r, out_index_nxt;

  logic               mem_we;
  logic [SLOT_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  logic               accept;
  logic               bad_cfg;
  logic [KEY_W-1:0]   rd_key;
  logic [OIDX_W-1:0]  rd_idx;
  logic [BCNT_W-1:0]  next_slot;

  lph_mod_req_t mod_req;
  lph_mod_rsp_t mod_rsp;

  lph_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign rd_key = rd_data_r[KEY_W-1:0];
  assign rd_idx = rd_data_r[ENTRY_W-1:KEY_W];

  assign bad_cfg = (bucket_count_r == '0) ||
                   (bucket_count_r > BCNT_W'(MAX_BUCKETS)) ||
                   (object_limit_r > OLIM_W'(MAX_OBJECTS)) ||
                   (range_mode_r && (object_limit_r == '0));

  assign next_slot = {1'b0, cur_r} + BCNT_W'(1);

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    cur_nxt        = cur_r;
    home_nxt       = home_r;
    key_nxt        = key_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_index_nxt  = out_index_r;
    mem_we         = 1'b0;
    mem_waddr      = in_slot;
    mem_wdata      = {in_object_index, in_key};
    mod_req.go       = 1'b0;
    mod_req.dividend = in_key;
    mod_req.divisor  = bucket_count_r;

    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == SLOT_W'(MAX_BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          out_slot_nxt  = '0;
          out_index_nxt = '0;
          if (in_req_type == REQ_WRITE) begin
            mem_we         = 1'b1;
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_WRITTEN;
          end else if (bad_cfg) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_BADCFG;
          end else begin
            key_nxt    = in_key;
            mod_req.go = 1'b1;
            state_nxt  = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mod_rsp.done) begin
          cur_nxt   = mod_rsp.rem[SLOT_W-1:0];
          home_nxt  = mod_rsp.rem[SLOT_W-1:0];
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        // table word for cur_r lands in rd_data_r at the next edge
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (rd_key == key_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (rd_idx >= OIDX_W'(object_limit_r)) begin
            if (range_mode_r) begin
              out_status_nxt = ST_NOTFOUND;
            end else begin
              out_status_nxt = ST_FOUND;
              out_slot_nxt   = cur_r;
            end
          end else begin
            out_status_nxt = ST_FOUND;
            out_slot_nxt   = cur_r;
            out_index_nxt  = rd_idx[FIDX_W-1:0];
          end
        end else if (rd_key == '0) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NOTFOUND;
          state_nxt      = S_IDLE;
        end else begin
          // advance with wrap; stop after a full circle
          if (next_slot >= bucket_count_r) begin
            cur_nxt = '0;
          end else begin
            cur_nxt = next_slot[SLOT_W-1:0];
          end
          if (cur_nxt == home_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_NOTFOUND;
            state_nxt      = S_IDLE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[cur_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r        <= cur_nxt;
    home_r       <= home_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_index_r  <= out_index_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= '0;
      object_limit_r <= '0;
      range_mode_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BUCKET_COUNT: bucket_count_r <= cfg_wdata[BCNT_W-1:0];
        CFG_OBJECT_LIMIT: object_limit_r <= cfg_wdata[OLIM_W-1:0];
        CFG_RANGE_MODE:   range_mode_r   <= cfg_wdata[0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_slot  = out_slot_r;
  assign out_found_index = out_index_r;

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_valid || (state_r == S_MOD)))
    else $error("accepted word neither answered nor started a lookup");

  a_mod_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mod_rsp.done |-> (state_r == S_MOD))
    else $error("remainder done outside the hash phase");

  a_cmp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> ($past(state_r) == S_RD))
    else $error("compare without a preceding table read");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_FOUND)) |->
      ((out_found_slot == '0) && (out_found_index == '0)))
    else $error("non-found result carries slot or index");

endmodule

// ===== hw/rtl/lph_mod_unit.sv =====
// Restoring remainder unit: 32-bit dividend by an 11-bit divisor, one bit a cycle.
// Depends on lph_pkg.
module lph_mod_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lph_pkg::lph_mod_req_t req,
  output lph_pkg::lph_mod_rsp_t rsp
);
  import lph_pkg::*;

  localparam int CNT_W = $clog2(KEY_W);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [KEY_W-1:0]  dvd_r, dvd_nxt;
  logic [BCNT_W-1:0] dsr_r, dsr_nxt;
  logic [BCNT_W-1:0] rem_r, rem_nxt;
  logic [BCNT_W:0]   trial;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[KEY_W-1]};
    if (req.go) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      dvd_nxt = req.dividend;
      dsr_nxt = req.divisor;
      rem_nxt = '0;
    end else if (run_r) begin
      // remainder stays below the divisor, so it fits back into BCNT_W bits
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = BCNT_W'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = trial[BCNT_W-1:0];
      end
      dvd_nxt = {dvd_r[KEY_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(KEY_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== test/tb_linear_probe_hash_lookup_core.sv =====
// Self-checking testbench for linear_probe_hash_lookup_core: directed probe cases, then random
// table traffic under several register settings, checked against an in-bench lookup predictor.
// Depends on lph_pkg and the core RTL only.
module tb_linear_probe_hash_lookup_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lph_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned MAX_PRINTED    = 50;
  localparam int unsigned POOL_SIZE      = 24;
  localparam logic [1:0]  CFG_UNUSED     = 2'd3;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [FIDX_W-1:0] index;
  } lookup_result_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_req_type;
  logic [SLOT_W-1:0]   in_slot;
  logic [KEY_W-1:0]    in_key;
  logic [OIDX_W-1:0]   in_object_index;
  logic                out_valid;
  logic [1:0]          out_status;
  logic [SLOT_W-1:0]   out_found_slot;
  logic [FIDX_W-1:0]   out_found_index;
  logic                cfg_we;
  logic [1:0]          cfg_index;
  logic [CFG_W-1:0]    cfg_wdata;

  // Predictor copy of the bucket table and registers
  logic [KEY_W-1:0]    tbl_key   [MAX_BUCKETS];
  logic [OIDX_W-1:0]   tbl_index [MAX_BUCKETS];
  logic [BCNT_W-1:0]   cur_bucket_count;
  logic [OLIM_W-1:0]   cur_object_limit;
  logic                cur_range_mode;

  lookup_result_t      pending_outcomes[$];
  lookup_result_t      exp_word;
  logic [KEY_W-1:0]    key_pool [POOL_SIZE];
  int unsigned         mismatch_count;
  int unsigned         idle_cycles;
  bit                  no_gaps;

  linear_probe_hash_lookup_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_slot         (in_slot),
    .in_key          (in_key),
    .in_object_index (in_object_index),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_found_slot  (out_found_slot),
    .out_found_index (out_found_index),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  function automatic lookup_result_t lookup_outcome(logic req, logic [SLOT_W-1:0] slot,
                                                    logic [KEY_W-1:0] key,
                                                    logic [OIDX_W-1:0] oidx);
    lookup_result_t    res;
    int unsigned       pos;
    int unsigned       bc;
    logic [OIDX_W-1:0] idx;
    res = '0;
    bc  = 32'(cur_bucket_count);
    if (req == REQ_WRITE) begin
      tbl_key[slot]   = key;
      tbl_index[slot] = oidx;
      res.status      = ST_WRITTEN;
      return res;
    end
    if (bc == 0 || bc > MAX_BUCKETS || cur_object_limit > MAX_OBJECTS ||
        (cur_range_mode && cur_object_limit == '0)) begin
      res.status = ST_BADCFG;
      return res;
    end
    res.status = ST_NOTFOUND;
    pos = key % bc;
    // Key compare comes before the empty test, so a zero key matches an empty slot
    for (int unsigned n = 0; n < bc; n++) begin
      if (tbl_key[pos] == key) begin
        idx = tbl_index[pos];
        if (idx >= cur_object_limit) begin
          if (cur_range_mode) return res;
          idx = '0;
        end
        res.status = ST_FOUND;
        res.slot   = pos[SLOT_W-1:0];
        res.index  = idx[FIDX_W-1:0];
        return res;
      end
      if (tbl_key[pos] == '0) return res;
      pos = (pos + 1 == bc) ? 0 : pos + 1;
    end
    return res;
  endfunction

  // Drop start and hold until every expected word is back and the core is free
  task automatic wait_drained();
    start = 1'b0;
    while (pending_outcomes.size() != 0 || busy !== 1'b0) @(negedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, int unsigned value);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value[CFG_W-1:0];
    @(posedge clk);
    case (idx)
      CFG_BUCKET_COUNT: cur_bucket_count = value[BCNT_W-1:0];
      CFG_OBJECT_LIMIT: cur_object_limit = value[OLIM_W-1:0];
      CFG_RANGE_MODE:   cur_range_mode   = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(int unsigned bc, int unsigned lim, int unsigned mode);
    set_reg(CFG_BUCKET_COUNT, bc);
    set_reg(CFG_OBJECT_LIMIT, lim);
    set_reg(CFG_RANGE_MODE, mode);
  endtask

  // Called and returns at a falling edge; start stays high so a back-to-back word needs no toggle
  task automatic send_item(logic req, logic [SLOT_W-1:0] slot, logic [KEY_W-1:0] key,
                           logic [OIDX_W-1:0] oidx);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req_type     = req;
    in_slot         = slot;
    in_key          = key;
    in_object_index = oidx;
    start           = 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pending_outcomes.push_back(lookup_outcome(req, slot, key, oidx));
    @(negedge clk);
  endtask

  task automatic test_reset_defaults();
    // All registers zero: lookups see a bad bucket count, writes still complete
    send_item(REQ_LOOKUP, 10'd0, 32'h0000_1234, 32'd0);
    send_item(REQ_WRITE, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_config_checks();
    set_config(8191, 4096, 0);
    send_item(REQ_LOOKUP, 10'h155, 32'h0000_0001, 32'd0);
    set_reg(CFG_BUCKET_COUNT, 1025);
    send_item(REQ_LOOKUP, 10'h2AA, 32'h0000_0001, 32'd0);
    set_reg(CFG_BUCKET_COUNT, 1024);
    set_reg(CFG_OBJECT_LIMIT, 8191);
    send_item(REQ_LOOKUP, 10'd0, 32'h0000_0002, 32'd0);
    set_reg(CFG_OBJECT_LIMIT, 4097);
    send_item(REQ_LOOKUP, 10'd0, 32'h0000_0002, 32'd0);
    set_config(1024, 0, 1);
    send_item(REQ_LOOKUP, 10'd0, 32'h0000_0003, 32'd0);
    // Index past the register list must leave every register alone
    set_reg(CFG_UNUSED, 8191);
    send_item(REQ_LOOKUP, 10'd0, 32'h0000_0003, 32'd0);
  endtask

  task automatic test_probe_cases();
    set_config(1024, 0, 0);
    send_item(REQ_WRITE, 10'h3FF, 32'hFFFF_FFFF, 32'd4095);
    send_item(REQ_LOOKUP, 10'd0, 32'hFFFF_FFFF, 32'd0);
    set_reg(CFG_OBJECT_LIMIT, 4096);
    send_item(REQ_LOOKUP, 10'd0, 32'hFFFF_FFFF, 32'd0);
    send_item(REQ_LOOKUP, 10'd0, 32'd0, 32'd0);
    send_item(REQ_WRITE, 10'd0, 32'd2048, 32'd7);
    send_item(REQ_LOOKUP, 10'd0, 32'd0, 32'd0);
    send_item(REQ_LOOKUP, 10'd0, 32'd2048, 32'd0);
    send_item(REQ_LOOKUP, 10'd0, 32'd4096, 32'd0);
    // Three full slots: wrap past the end and a miss that circles the whole table
    set_reg(CFG_BUCKET_COUNT, 3);
    send_item(REQ_WRITE, 10'd0, 32'd5, 32'd1);
    send_item(REQ_WRITE, 10'd1, 32'd6, 32'd2);
    send_item(REQ_WRITE, 10'd2, 32'd7, 32'd3);
    send_item(REQ_LOOKUP, 10'd0, 32'd8, 32'd0);
    send_item(REQ_LOOKUP, 10'd0, 32'd5, 32'd0);
    send_item(REQ_LOOKUP, 10'd0, 32'd6, 32'd0);
    set_config(3, 2, 1);
    send_item(REQ_LOOKUP, 10'd0, 32'd7, 32'd0);
    send_item(REQ_LOOKUP, 10'd0, 32'd5, 32'd0);
    set_reg(CFG_RANGE_MODE, 0);
    send_item(REQ_LOOKUP, 10'd0, 32'd7, 32'd0);
    set_reg(CFG_BUCKET_COUNT, 1);
    send_item(REQ_LOOKUP, 10'd0, 32'd5, 32'd0);
  endtask

  task automatic run_traffic(int unsigned count, int unsigned bc, int unsigned lim);
    int unsigned       sel;
    int unsigned       span;
    bit                bc_ok;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
    logic [OIDX_W-1:0] oidx;
    bc_ok = (bc != 0 && bc <= MAX_BUCKETS);
    span  = bc_ok ? bc : 64;
    for (int unsigned i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = (i % 2 == 0) ? $urandom_range(1, 4 * span + 8) : $urandom;
      if (key_pool[i] == '0) key_pool[i] = 32'd1;
    end
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 39) == 0) wait_drained();
      sel  = $urandom_range(0, 99);
      key  = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      slot = SLOT_W'($urandom);
      oidx = ($urandom_range(0, 9) < 7) ? $urandom_range(0, lim + lim / 4 + 2) : $urandom;
      if (sel < 40) begin
        // Insert near the home slot so lookups walk real probe chains
        if (sel < 4) key = '0;
        else if (sel < 8) key = $urandom;
        if (bc_ok && key != '0 && sel >= 8)
          slot = SLOT_W'((key % bc + $urandom_range(0, 3)) % bc);
        else if (bc_ok) slot = SLOT_W'($urandom_range(0, bc - 1));
        send_item(REQ_WRITE, slot, key, oidx);
      end else begin
        if (sel < 50) key = '0;
        else if (sel < 68) key = $urandom;
        send_item(REQ_LOOKUP, slot, key, $urandom);
      end
    end
  endtask

  task automatic test_random_traffic();
    int unsigned bc;
    int unsigned lim;
    int unsigned mode;
    int unsigned sel;
    for (int unsigned ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin bc = 1;    lim = 4096; mode = 0; end
        1: begin bc = 1024; lim = 4096; mode = 1; end
        2: begin bc = 1024; lim = 1;    mode = 1; end
        3: begin bc = 2;    lim = 0;    mode = 0; end
        default: begin
          sel  = $urandom_range(0, 9);
          bc   = (sel < 6) ? $urandom_range(2, 40) :
                 (sel < 9) ? $urandom_range(41, 1024) : $urandom_range(0, 8191);
          lim  = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 4096) : $urandom_range(0, 8191);
          mode = $urandom_range(0, 1);
        end
      endcase
      set_config(bc, lim, mode);
      no_gaps = (ph % 3 == 1);
      run_traffic(100, 32'(cur_bucket_count), 32'(cur_object_limit));
      no_gaps = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch($sformatf("result word with nothing pending, status %0d", out_status));
      end else begin
        exp_word = pending_outcomes.pop_front();
        if (out_status !== exp_word.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_status, exp_word.status));
        if (out_found_slot !== exp_word.slot)
          report_mismatch($sformatf("found_slot %0d, expected %0d",
                                    out_found_slot, exp_word.slot));
        if (out_found_index !== exp_word.index)
          report_mismatch($sformatf("found_index %0d, expected %0d",
                                    out_found_index, exp_word.index));
      end
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_req_type     = REQ_WRITE;
    in_slot         = '0;
    in_key          = '0;
    in_object_index = '0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_BUCKET_COUNT;
    cfg_wdata       = '0;
    mismatch_count  = 0;
    no_gaps         = 1'b0;
    cur_bucket_count = '0;
    cur_object_limit = '0;
    cur_range_mode   = 1'b0;
    for (int i = 0; i < MAX_BUCKETS; i++) begin
      tbl_key[i]   = '0;
      tbl_index[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_config_checks();
    test_probe_cases();
    test_random_traffic();

    wait_drained();
    // Catch any stray word after the last expected one
    repeat (100) @(posedge clk);
    if (pending_outcomes.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", pending_outcomes.size()));
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
